// ----- rtl/fdme_pkg.sv -----
// Shared constants, coefficient-generation constants and types for the FIR decimator.
`default_nettype none

package fdme_pkg;

  localparam int SampleW  = 16;
  localparam int HistW    = SampleW + 1;
  localparam int CoefW    = 19;
  localparam int ProdW    = CoefW + HistW;
  localparam int CodeW    = 8;
  localparam int AccShift = 18;

  localparam int TapCountDef   = 129;
  localparam int DecimationDef = 6;

  localparam int UlawBias = 'h84;
  localparam int UlawClip = 32635;
  localparam int SmpMax   = 32767;
  localparam int SmpMin   = -32768;

  // Q30 constants for the elaboration-time coefficient build
  localparam longint OneQ30    = 64'sd1073741824;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint HamAQ30   = 64'sd579820585;
  localparam longint HamBQ30   = 64'sd493921239;
  localparam longint CutNum    = 64'sd17;
  localparam longint CutDen    = 64'sd240;
  localparam longint CoefScale = 64'sd131072;

  // (m+1)(m+2) divisors of the Taylor terms, sine and cosine series
  localparam longint TaylorDivOdd [12] = '{
    64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156,
    64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600
  };
  localparam longint TaylorDivEven [12] = '{
    64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90, 64'sd132,
    64'sd182, 64'sd240, 64'sd306, 64'sd380, 64'sd462, 64'sd552
  };

  typedef struct packed {
    logic clr;  // start a new sum
    logic vld;  // operands at the MAC inputs are a live tap
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/fdme_in_if.sv -----
// Sample-pair input channel.
`default_nettype none

interface fdme_in_if import fdme_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_sample;
  logic signed [SampleW-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/fdme_out_if.sv -----
// Result channel: mu-law byte and filtered sample.
`default_nettype none

interface fdme_out_if import fdme_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [CodeW-1:0]   ulaw_byte;
  logic signed [SampleW-1:0] filtered_sample;

  modport source (output valid, output ulaw_byte, output filtered_sample, input ready);
  modport sink   (input valid, input ulaw_byte, input filtered_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/fdme_cfg_if.sv -----
// Configuration write channel for the stereo_mode register.
`default_nettype none

interface fdme_cfg_if ();
  logic valid;
  logic ready;
  logic stereo_mode;

  modport source (output valid, output stereo_mode, input ready);
  modport sink   (input valid, input stereo_mode, output ready);
endinterface

`default_nettype wire

// ----- rtl/fdme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fdme_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 129
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/fdme_coef_rom.sv -----
// Hamming-windowed sinc coefficient table, built at elaboration, registered read.
`default_nettype none

module fdme_coef_rom import fdme_pkg::*; #(
  parameter int TAP_COUNT = TapCountDef
) (
  input  wire logic                         clk_i,
  input  wire logic [$clog2(TAP_COUNT)-1:0] addr_i,
  output      logic signed [CoefW-1:0]      coef_o
);

  localparam longint SincQ = 2 * CutDen;
  localparam longint WinQ  = 4 * (longint'(TAP_COUNT) - 1);

  function automatic longint taylor_q30(longint a, bit odd);
    longint term;
    longint acc;
    term = odd ? a : OneQ30;
    acc  = term;
    for (int k = 0; k < 12; k++) begin
      if (odd) begin
        term = -(((term * a) / OneQ30) * a / OneQ30) / TaylorDivOdd[k];
      end else begin
        term = -(((term * a) / OneQ30) * a / OneQ30) / TaylorDivEven[k];
      end
      acc += term;
    end
    return acc;
  endfunction

  // signed divide truncating toward zero, by shift and subtract
  function automatic longint div_trunc(longint num, longint den);
    longint unsigned n_mag;
    longint unsigned d_mag;
    longint unsigned quo;
    longint unsigned part;
    n_mag = (num < 0) ? -num : num;
    d_mag = (den < 0) ? -den : den;
    quo   = '0;
    part  = '0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[62:0], n_mag[b]};
      if (part >= d_mag) begin
        part   -= d_mag;
        quo[b] = 1'b1;
      end
    end
    return ((num < 0) != (den < 0)) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic longint quad_eval(longint quad, longint a);
    longint res;
    case (quad)
      64'sd0:  res = taylor_q30(a, 1'b1);
      64'sd1:  res = taylor_q30(a, 1'b0);
      64'sd2:  res = -taylor_q30(a, 1'b1);
      default: res = -taylor_q30(a, 1'b0);
    endcase
    return res;
  endfunction

  // sin(2*pi*p/480)
  function automatic longint sin_sinc(longint p);
    longint r;
    longint quad;
    longint rem;
    r = p % SincQ;
    if (r < 0) begin
      r += SincQ;
    end
    quad = (4 * r) / SincQ;
    rem  = 4 * r - quad * SincQ;
    return quad_eval(quad, HalfPiQ30 * rem / SincQ);
  endfunction

  // sin(2*pi*p/(4*(TAP_COUNT-1)))
  function automatic longint sin_win(longint p);
    longint r;
    longint quad;
    longint rem;
    r = p % WinQ;
    if (r < 0) begin
      r += WinQ;
    end
    quad = (4 * r) / WinQ;
    rem  = 4 * r - quad * WinQ;
    return quad_eval(quad, HalfPiQ30 * rem / WinQ);
  endfunction

  function automatic longint raw_tap(int t);
    longint d;
    longint val;
    longint cw;
    longint win;
    d = 2 * longint'(t) - (longint'(TAP_COUNT) - 1);
    if (d == 0) begin
      val = 4 * HalfPiQ30 * CutNum / CutDen;
    end else begin
      val = div_trunc(2 * sin_sinc(CutNum * d), d);
    end
    cw  = sin_win(4 * longint'(t) + longint'(TAP_COUNT) - 1);
    win = HamAQ30 - HamBQ30 * cw / OneQ30;
    return val * win / OneQ30;
  endfunction

  function automatic longint total_raw();
    longint sum;
    sum = 0;
    for (int t = 0; t < TAP_COUNT; t++) begin
      sum += raw_tap(t);
    end
    return sum;
  endfunction

  localparam longint TotalRaw  = total_raw();
  localparam longint CoefTotal = (TotalRaw <= 0) ? 64'sd1 : TotalRaw;

  // unit DC gain, round half away from zero
  function automatic longint coef_at(int t);
    longint p;
    longint res;
    p = raw_tap(t) * CoefScale;
    if (p >= 0) begin
      res = (p + CoefTotal / 2) / CoefTotal;
    end else begin
      res = -((-p + CoefTotal / 2) / CoefTotal);
    end
    return res;
  endfunction

  logic signed [CoefW-1:0] rom_w [TAP_COUNT];
  logic signed [CoefW-1:0] coef_q;

  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_tap
    localparam longint CoefVal = coef_at(g);
    assign rom_w[g] = CoefW'(CoefVal);
  end

  always_ff @(posedge clk_i) begin
    coef_q <= rom_w[addr_i];
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// ----- rtl/fdme_mac.sv -----
// Shared multiply-accumulate unit: registered product, then running sum.
`default_nettype none

module fdme_mac import fdme_pkg::*; #(
  parameter int ACC_W = ProdW + 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mac_ctrl_t               ctrl_i,
  input  wire logic signed [CoefW-1:0] coef_i,
  input  wire logic signed [HistW-1:0] smp_i,
  output      logic signed [ACC_W-1:0] acc_o
);

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(coef_i) * ProdW'(smp_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.vld & ~ctrl_i.clr;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/fdme_enc.sv -----
// Scales the sum to int16 with saturation and forms the mu-law code.
`default_nettype none

module fdme_enc import fdme_pkg::*; #(
  parameter int ACC_W = ProdW + 8
) (
  input  wire logic signed [ACC_W-1:0]   acc_i,
  output      logic signed [SampleW-1:0] smp_o,
  output      logic        [CodeW-1:0]   code_o
);

  localparam int QW = ACC_W - AccShift;
  localparam logic signed [QW-1:0] QMax = QW'(SmpMax);
  localparam logic signed [QW-1:0] QMin = QW'(SmpMin);

  logic signed [ACC_W-1:0]   rnd_bias;
  logic signed [ACC_W-1:0]   acc_adj;
  logic signed [QW-1:0]      q;
  logic signed [SampleW-1:0] y;
  logic        [SampleW:0]   ys;
  logic        [SampleW:0]   mag;
  logic        [SampleW:0]   mag_clip;
  logic        [14:0]        mag_b;
  logic        [14:0]        lvl_sh;
  logic        [2:0]         seg;

  always_comb begin
    // truncate toward zero: bias negatives before the arithmetic shift
    rnd_bias = acc_i[ACC_W-1] ? {{(ACC_W-AccShift){1'b0}}, {AccShift{1'b1}}} : '0;
    acc_adj  = acc_i + rnd_bias;
    q        = acc_adj[ACC_W-1:AccShift];
    if (q > QMax) begin
      y = SampleW'(SmpMax);
    end else if (q < QMin) begin
      y = SampleW'(SmpMin);
    end else begin
      y = q[SampleW-1:0];
    end

    ys       = {y[SampleW-1], y};
    mag      = ys[SampleW] ? (~ys + 1'b1) : ys;
    mag_clip = (mag > (SampleW+1)'(UlawClip)) ? (SampleW+1)'(UlawClip) : mag;
    mag_b    = mag_clip[14:0] + 15'(UlawBias);

    seg = 3'd0;
    for (int s = 1; s < 8; s++) begin
      if (mag_b[s+7]) begin
        seg = 3'(s);
      end
    end
    lvl_sh = mag_b >> (4'(seg) + 4'd3);

    smp_o  = y;
    code_o = ~{y[SampleW-1], seg, lvl_sh[3:0]};
  end

endmodule

`default_nettype wire

// ----- rtl/fir_decimator_mulaw_encoder.sv -----
// Flow: an item that does not complete a decimation group is taken in S_IDLE with no filter pass.
// A group-completing item runs a MAC pass over all TAP_COUNT taps, then S_DRAIN and S_OUT:
// its result becomes valid, and input ready again, when S_OUT loads the output register,
// which waits while an earlier result is still held. No new item is taken until then; the
// single MAC steps one tap per cycle in S_MAC. Reset (async, low) clears
// the history valid bits (history reads as zero), pointers, phase; stereo_mode = 1.
`default_nettype none

module fir_decimator_mulaw_encoder import fdme_pkg::*; #(
  parameter int TAP_COUNT  = TapCountDef,
  parameter int DECIMATION = DecimationDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fdme_in_if.sink     smp_i,
  fdme_cfg_if.sink    cfg_i,
  fdme_out_if.source  res_o
);

  localparam int PtrW = $clog2(TAP_COUNT);
  localparam int PhW  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int AccW = ProdW + $clog2(TAP_COUNT);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  localparam logic [PtrW-1:0] LastTap   = PtrW'(TAP_COUNT - 1);
  localparam logic [PhW-1:0]  LastPhase = PhW'(DECIMATION - 1);

  logic [1:0]           state_q, state_d;
  logic [PtrW-1:0]      wp_q, wp_d, wp_inc;
  logic [PtrW-1:0]      rd_idx_q, rd_idx_d;
  logic [PtrW-1:0]      tap_q, tap_d;
  logic [PhW-1:0]       phase_q, phase_d;
  logic                 drain_q, drain_d;
  logic                 stereo_q;
  logic [TAP_COUNT-1:0] hist_vld_q;
  logic                 vbit_q;
  logic                 iss_vld_q;
  logic                 issue;
  logic                 in_acc;
  logic                 dec_hit;
  logic                 load_res;
  mac_ctrl_t            mac_ctrl;

  logic signed [HistW-1:0]   kept;
  logic        [HistW-1:0]   ram_rdata;
  logic signed [HistW-1:0]   mac_smp;
  logic signed [CoefW-1:0]   coef;
  logic signed [AccW-1:0]    acc;
  logic signed [SampleW-1:0] enc_smp;
  logic        [CodeW-1:0]   enc_code;

  logic                      res_vld_q;
  logic        [CodeW-1:0]   res_code_q;
  logic signed [SampleW-1:0] res_smp_q;

  assign smp_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = smp_i.valid & smp_i.ready;
  assign dec_hit     = (phase_q == LastPhase);
  assign wp_inc      = (wp_q == LastTap) ? '0 : wp_q + 1'b1;

  always_comb begin
    if (stereo_q) begin
      kept = HistW'(smp_i.left_sample) + HistW'(smp_i.right_sample);
    end else begin
      kept = {smp_i.left_sample, 1'b0};
    end
  end

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    rd_idx_d     = rd_idx_q;
    tap_d        = tap_q;
    phase_d      = phase_q;
    drain_d      = drain_q;
    issue        = 1'b0;
    load_res     = 1'b0;
    mac_ctrl.clr = 1'b0;
    mac_ctrl.vld = iss_vld_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          wp_d = wp_inc;
          if (dec_hit) begin
            phase_d      = '0;
            tap_d        = '0;
            rd_idx_d     = wp_inc;  // oldest entry after this write
            mac_ctrl.clr = 1'b1;
            state_d      = S_MAC;
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      S_MAC: begin
        issue    = 1'b1;
        tap_d    = tap_q + 1'b1;
        rd_idx_d = (rd_idx_q == LastTap) ? '0 : rd_idx_q + 1'b1;
        drain_d  = 1'b0;
        if (tap_q == LastTap) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // drain the RAM/ROM read register, then the product register
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_vld_q || res_o.ready) begin
          load_res = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wp_q       <= '0;
      rd_idx_q   <= '0;
      tap_q      <= '0;
      phase_q    <= '0;
      drain_q    <= 1'b0;
      stereo_q   <= 1'b1;
      hist_vld_q <= '0;
      iss_vld_q  <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rd_idx_q  <= rd_idx_d;
      tap_q     <= tap_d;
      phase_q   <= phase_d;
      drain_q   <= drain_d;
      iss_vld_q <= issue;
      if (cfg_i.valid) begin
        stereo_q <= cfg_i.stereo_mode;
      end
      if (in_acc) begin
        hist_vld_q[wp_q] <= 1'b1;
      end
      if (load_res) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vbit_q <= hist_vld_q[rd_idx_q];
    if (load_res) begin
      res_code_q <= enc_code;
      res_smp_q  <= enc_smp;
    end
  end

  fdme_ram #(
    .WIDTH (HistW),
    .DEPTH (TAP_COUNT)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i (kept),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  fdme_coef_rom #(
    .TAP_COUNT (TAP_COUNT)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (tap_q),
    .coef_o (coef)
  );

  // never-written history entries read as zero
  assign mac_smp = vbit_q ? $signed(ram_rdata) : '0;

  fdme_mac #(
    .ACC_W (AccW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef),
    .smp_i  (mac_smp),
    .acc_o  (acc)
  );

  fdme_enc #(
    .ACC_W (AccW)
  ) u_enc (
    .acc_i  (acc),
    .smp_o  (enc_smp),
    .code_o (enc_code)
  );

  assign res_o.valid           = res_vld_q;
  assign res_o.ulaw_byte       = res_code_q;
  assign res_o.filtered_sample = res_smp_q;

  a_no_dec_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !dec_hit) |=> (state_q == S_IDLE))
    else $error("non-decimating beat started a filter pass");

  a_dec_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && dec_hit) |=> (state_q == S_MAC && tap_q == '0 && phase_q == '0))
    else $error("decimating beat did not start a filter pass at tap zero");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> ($past(state_q) == S_OUT))
    else $error("result loaded outside the output state");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q <= LastTap) && (rd_idx_q <= LastTap))
    else $error("history pointer out of range");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (tap_q <= LastTap))
    else $error("tap counter out of range");

endmodule

`default_nettype wire
